@@ rtl/core/timed_actuator_pulse_controller_unit_assert.svh @@
// assertion macros for the timed actuator pulse controller
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef TIMED_ACTUATOR_PULSE_CONTROLLER_UNIT_ASSERT_SVH
`define TIMED_ACTUATOR_PULSE_CONTROLLER_UNIT_ASSERT_SVH

// checked only while out of reset
`define TAPC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("tapc assertion failed");

// checked on every edge, reset included
`define TAPC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("tapc assertion failed");

`endif

@@ rtl/core/tapc_pkg.sv @@
// shared widths, reset values and register indexes of the pulse controller
// no dependencies
`default_nettype none

package tapc_pkg;

  localparam int unsigned CODE_W     = 6;
  localparam int unsigned TICK_W     = 8;
  localparam int unsigned SIREN_W    = 10;
  localparam int unsigned ANGLE_W    = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 10;

  // command code bits
  localparam int unsigned BIT_LIGHT_ON  = 0;
  localparam int unsigned BIT_LIGHT_OFF = 1;
  localparam int unsigned BIT_DOOR      = 2;
  localparam int unsigned BIT_FEED      = 3;
  localparam int unsigned BIT_SIREN     = 4;

  // register reset values
  localparam logic [TICK_W-1:0]  RST_PULSE_TICKS = 8'd100;
  localparam logic [TICK_W-1:0]  RST_BLINK_TICKS = 8'd10;
  localparam logic [SIREN_W-1:0] RST_SIREN_TICKS = 10'd500;
  localparam logic [ANGLE_W-1:0] RST_FEED_ACTIVE = 8'd180;
  localparam logic [ANGLE_W-1:0] RST_FEED_REST   = 8'd70;
  localparam logic [ANGLE_W-1:0] RST_DOOR_ACTIVE = 8'd180;
  localparam logic [ANGLE_W-1:0] RST_DOOR_REST   = 8'd60;

  // servo positions after reset
  localparam logic [ANGLE_W-1:0] RST_FEED_POS = 8'd60;
  localparam logic [ANGLE_W-1:0] RST_DOOR_POS = 8'd70;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PULSE_TICKS = 3'd0,
    CFG_BLINK_TICKS = 3'd1,
    CFG_SIREN_TICKS = 3'd2,
    CFG_FEED_ACTIVE = 3'd3,
    CFG_FEED_REST   = 3'd4,
    CFG_DOOR_ACTIVE = 3'd5,
    CFG_DOOR_REST   = 3'd6
  } cfg_idx_e;

endpackage

`default_nettype wire

@@ rtl/core/tapc_in_if.sv @@
// input channel of the pulse controller: one tick with an optional command
// depends on tapc_pkg
`default_nettype none

interface tapc_in_if;
  import tapc_pkg::*;

  logic              valid;
  logic              ready;
  logic              cmd_valid;
  logic [CODE_W-1:0] cmd_code;

  modport source (output valid, output cmd_valid, output cmd_code, input ready);
  modport sink   (input valid, input cmd_valid, input cmd_code, output ready);
endinterface

`default_nettype wire

@@ rtl/core/tapc_out_if.sv @@
// output channel of the pulse controller: actuator levels after each tick
// depends on tapc_pkg
`default_nettype none

interface tapc_out_if;
  import tapc_pkg::*;

  logic               valid;
  logic               ready;
  logic               light_level;
  logic               siren_lamp;
  logic [ANGLE_W-1:0] feed_angle;
  logic [ANGLE_W-1:0] door_angle;
  logic               feed_busy;
  logic               door_busy;
  logic               siren_busy;

  modport source (
    output valid, output light_level, output siren_lamp, output feed_angle,
    output door_angle, output feed_busy, output door_busy, output siren_busy,
    input ready
  );
  modport sink (
    input valid, input light_level, input siren_lamp, input feed_angle,
    input door_angle, input feed_busy, input door_busy, input siren_busy,
    output ready
  );
endinterface

`default_nettype wire

@@ rtl/core/timed_actuator_pulse_controller_unit.sv @@
// timed actuator pulse controller: light, feeder and door pulses, siren lamp
// depends on tapc_pkg, tapc_in_if, tapc_out_if and the assertion header
`default_nettype none

`include "timed_actuator_pulse_controller_unit_assert.svh"

// usage
// - in_i carries one timer tick per item, with cmd_valid/cmd_code; every item
//   gives exactly one item on out_o, holding the actuator state after the tick
// - configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
//   (pulse_ticks, blink_ticks, siren_ticks, then the four servo angles);
//   write only while no tick is in flight
// - path: the input register, then the state update into the result register
// - throughput: one tick per clock while out_o takes results; the limit is the single
//   state update that each tick needs against the state left by the one before
// - the input register takes a new tick while the result register still holds
//   an untaken result, so the two sides are decoupled by one item
// - receiver stall: the result holds, the input register fills, then in_i
//   drops ready until out_o is drained; no item is lost
// - reset (rst_ni low, async): light and siren lamp on, feeder at 60 and door
//   at 70 degrees, all pulses idle, registers back to their defaults
module timed_actuator_pulse_controller_unit (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  tapc_in_if.sink                               in_i,
  tapc_out_if.source                            out_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [tapc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [tapc_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import tapc_pkg::*;

  // configuration registers
  logic [TICK_W-1:0]  pulse_ticks_q, blink_ticks_q;
  logic [SIREN_W-1:0] siren_ticks_q;
  logic [ANGLE_W-1:0] feed_act_q, feed_rest_q, door_act_q, door_rest_q;

  // input register
  logic              s1_valid_q;
  logic              s1_cmd_valid_q;
  logic [CODE_W-1:0] s1_code_q;

  // controller state
  logic               feed_active_q, feed_active_d;
  logic [TICK_W-1:0]  feed_count_q, feed_count_d;
  logic               door_active_q, door_active_d;
  logic [TICK_W-1:0]  door_count_q, door_count_d;
  logic               siren_active_q, siren_active_d;
  logic [SIREN_W-1:0] siren_count_q, siren_count_d;
  logic [TICK_W-1:0]  blink_phase_q, blink_phase_d;
  logic               toggle_q, toggle_d;
  logic               light_q, light_d;
  logic               lamp_q, lamp_d;
  logic [ANGLE_W-1:0] feed_pos_q, feed_pos_d;
  logic [ANGLE_W-1:0] door_pos_q, door_pos_d;

  // result register
  logic               out_valid_q;
  logic               r_light_q, r_lamp_q, r_feed_busy_q, r_door_busy_q, r_siren_busy_q;
  logic [ANGLE_W-1:0] r_feed_angle_q, r_door_angle_q;

  // handshake
  logic out_free, s1_fire, in_fire;

  assign out_free = !out_valid_q || out_o.ready;
  assign s1_fire  = s1_valid_q && out_free;
  assign in_i.ready = !s1_valid_q || out_free;
  assign in_fire  = in_i.valid && in_i.ready;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_ticks_q <= RST_PULSE_TICKS;
      blink_ticks_q <= RST_BLINK_TICKS;
      siren_ticks_q <= RST_SIREN_TICKS;
      feed_act_q    <= RST_FEED_ACTIVE;
      feed_rest_q   <= RST_FEED_REST;
      door_act_q    <= RST_DOOR_ACTIVE;
      door_rest_q   <= RST_DOOR_REST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_PULSE_TICKS: pulse_ticks_q <= cfg_data_i[TICK_W-1:0];
        CFG_BLINK_TICKS: blink_ticks_q <= cfg_data_i[TICK_W-1:0];
        CFG_SIREN_TICKS: siren_ticks_q <= cfg_data_i[SIREN_W-1:0];
        CFG_FEED_ACTIVE: feed_act_q    <= cfg_data_i[ANGLE_W-1:0];
        CFG_FEED_REST:   feed_rest_q   <= cfg_data_i[ANGLE_W-1:0];
        CFG_DOOR_ACTIVE: door_act_q    <= cfg_data_i[ANGLE_W-1:0];
        CFG_DOOR_REST:   door_rest_q   <= cfg_data_i[ANGLE_W-1:0];
        default: ;  // unused index, write is dropped
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_cmd_valid_q <= in_i.cmd_valid;
      s1_code_q      <= in_i.cmd_code;
    end
  end

  // one tick of the controller: commands first, then the timers
  always_comb begin
    logic cmd;
    cmd = s1_cmd_valid_q;

    light_d        = light_q;
    feed_active_d  = feed_active_q;
    feed_count_d   = feed_count_q;
    feed_pos_d     = feed_pos_q;
    door_active_d  = door_active_q;
    door_count_d   = door_count_q;
    door_pos_d     = door_pos_q;
    siren_active_d = siren_active_q;
    siren_count_d  = siren_count_q;
    blink_phase_d  = blink_phase_q;
    toggle_d       = toggle_q;
    lamp_d         = lamp_q;

    // light off wins over light on
    if (cmd && s1_code_q[BIT_LIGHT_ON])  light_d = 1'b1;
    if (cmd && s1_code_q[BIT_LIGHT_OFF]) light_d = 1'b0;
    if (cmd && s1_code_q[BIT_FEED]) begin
      feed_pos_d    = feed_act_q;
      feed_active_d = 1'b1;
    end
    if (cmd && s1_code_q[BIT_DOOR]) begin
      door_pos_d    = door_act_q;
      door_active_d = 1'b1;
    end
    if (cmd && s1_code_q[BIT_SIREN]) siren_active_d = 1'b1;

    // retrigger keeps the running count
    if (feed_active_d) begin
      feed_count_d = feed_count_q + 1'b1;
      if (feed_count_d == pulse_ticks_q) begin
        feed_active_d = 1'b0;
        feed_count_d  = '0;
        feed_pos_d    = feed_rest_q;
      end
    end
    if (door_active_d) begin
      door_count_d = door_count_q + 1'b1;
      if (door_count_d == pulse_ticks_q) begin
        door_active_d = 1'b0;
        door_count_d  = '0;
        door_pos_d    = door_rest_q;
      end
    end

    // siren end takes priority over a lamp toggle on the same tick
    if (siren_active_d) begin
      siren_count_d = siren_count_q + 1'b1;
      blink_phase_d = blink_phase_q + 1'b1;
      if (siren_count_d == siren_ticks_q) begin
        siren_active_d = 1'b0;
        siren_count_d  = '0;
        blink_phase_d  = '0;
      end else if (blink_phase_d == blink_ticks_q) begin
        blink_phase_d = '0;
        toggle_d      = !toggle_q;
        lamp_d        = !toggle_q;
      end
    end
  end

  // state commit, once per tick leaving the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      light_q        <= 1'b1;
      lamp_q         <= 1'b1;
      toggle_q       <= 1'b0;
      feed_active_q  <= 1'b0;
      feed_count_q   <= '0;
      feed_pos_q     <= RST_FEED_POS;
      door_active_q  <= 1'b0;
      door_count_q   <= '0;
      door_pos_q     <= RST_DOOR_POS;
      siren_active_q <= 1'b0;
      siren_count_q  <= '0;
      blink_phase_q  <= '0;
    end else if (s1_fire) begin
      light_q        <= light_d;
      lamp_q         <= lamp_d;
      toggle_q       <= toggle_d;
      feed_active_q  <= feed_active_d;
      feed_count_q   <= feed_count_d;
      feed_pos_q     <= feed_pos_d;
      door_active_q  <= door_active_d;
      door_count_q   <= door_count_d;
      door_pos_q     <= door_pos_d;
      siren_active_q <= siren_active_d;
      siren_count_q  <= siren_count_d;
      blink_phase_q  <= blink_phase_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      r_light_q      <= light_d;
      r_lamp_q       <= lamp_d;
      r_feed_angle_q <= feed_pos_d;
      r_door_angle_q <= door_pos_d;
      r_feed_busy_q  <= feed_active_d;
      r_door_busy_q  <= door_active_d;
      r_siren_busy_q <= siren_active_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.light_level = r_light_q;
  assign out_o.siren_lamp  = r_lamp_q;
  assign out_o.feed_angle  = r_feed_angle_q;
  assign out_o.door_angle  = r_door_angle_q;
  assign out_o.feed_busy   = r_feed_busy_q;
  assign out_o.door_busy   = r_door_busy_q;
  assign out_o.siren_busy  = r_siren_busy_q;

  // checks
  `TAPC_ASSERT(a_feed_count_idle, (feed_count_q != '0) |-> feed_active_q)
  `TAPC_ASSERT(a_door_count_idle, (door_count_q != '0) |-> door_active_q)
  `TAPC_ASSERT_ALWAYS(a_siren_idle_clear,
    !siren_active_q |-> (siren_count_q == '0 && blink_phase_q == '0))
  `TAPC_ASSERT(a_accept_fills_s1, in_fire |=> s1_valid_q)
  `TAPC_ASSERT(a_state_holds, !s1_fire |=> $stable(siren_count_q) && $stable(light_q))

endmodule

`default_nettype wire

@@ tb/tapc_levels_checker.sv @@
// scoreboard for the pulse controller: mirrors the registers, predicts the levels after each tick
// and compares them with every item taken from the output channel
// depends on tapc_pkg, tapc_in_if and tapc_out_if
`timescale 1ns / 100ps

module tapc_levels_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  tapc_in_if                              tick_i,
  tapc_out_if                             levels_i,
  input  logic                            cfg_we_i,
  input  logic [tapc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tapc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                              fail_count_o,
  output int                              pending_o
);
  import tapc_pkg::*;

  typedef struct packed {
    logic               light;
    logic               lamp;
    logic [ANGLE_W-1:0] feed_angle;
    logic [ANGLE_W-1:0] door_angle;
    logic               feed_busy;
    logic               door_busy;
    logic               siren_busy;
  } actuator_levels_t;

  actuator_levels_t levels_due[$];

  // register copies
  logic [TICK_W-1:0]  pulse_len, blink_len;
  logic [SIREN_W-1:0] siren_len;
  logic [ANGLE_W-1:0] feed_act, feed_rest, door_act, door_rest;

  // actuator state copies
  logic               feed_on, door_on, siren_on, toggle, light, lamp;
  logic [TICK_W-1:0]  feed_cnt, door_cnt, blink_cnt;
  logic [SIREN_W-1:0] siren_cnt;
  logic [ANGLE_W-1:0] feed_pos, door_pos;

  function automatic void reset_model();
    pulse_len = RST_PULSE_TICKS;
    blink_len = RST_BLINK_TICKS;
    siren_len = RST_SIREN_TICKS;
    feed_act  = RST_FEED_ACTIVE;
    feed_rest = RST_FEED_REST;
    door_act  = RST_DOOR_ACTIVE;
    door_rest = RST_DOOR_REST;
    feed_on   = 1'b0;
    door_on   = 1'b0;
    siren_on  = 1'b0;
    feed_cnt  = '0;
    door_cnt  = '0;
    siren_cnt = '0;
    blink_cnt = '0;
    toggle    = 1'b0;
    light     = 1'b1;
    lamp      = 1'b1;
    feed_pos  = RST_FEED_POS;
    door_pos  = RST_DOOR_POS;
  endfunction

  function automatic void write_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    case (cfg_idx_e'(idx))
      CFG_PULSE_TICKS: pulse_len = data[TICK_W-1:0];
      CFG_BLINK_TICKS: blink_len = data[TICK_W-1:0];
      CFG_SIREN_TICKS: siren_len = data[SIREN_W-1:0];
      CFG_FEED_ACTIVE: feed_act  = data[ANGLE_W-1:0];
      CFG_FEED_REST:   feed_rest = data[ANGLE_W-1:0];
      CFG_DOOR_ACTIVE: door_act  = data[ANGLE_W-1:0];
      CFG_DOOR_REST:   door_rest = data[ANGLE_W-1:0];
      default: ;
    endcase
  endfunction

  // one timer tick: command first, then the counters
  function automatic void apply_tick(input logic cv, input logic [CODE_W-1:0] code);
    if (cv) begin
      if (code[BIT_LIGHT_ON]) light = 1'b1;
      if (code[BIT_LIGHT_OFF]) light = 1'b0;
      if (code[BIT_FEED]) begin
        feed_pos = feed_act;
        feed_on  = 1'b1;
      end
      if (code[BIT_DOOR]) begin
        door_pos = door_act;
        door_on  = 1'b1;
      end
      if (code[BIT_SIREN]) siren_on = 1'b1;
    end
    if (feed_on) begin
      feed_cnt = feed_cnt + 1'b1;
      if (feed_cnt == pulse_len) begin
        feed_on  = 1'b0;
        feed_cnt = '0;
        feed_pos = feed_rest;
      end
    end
    if (door_on) begin
      door_cnt = door_cnt + 1'b1;
      if (door_cnt == pulse_len) begin
        door_on  = 1'b0;
        door_cnt = '0;
        door_pos = door_rest;
      end
    end
    if (siren_on) begin
      siren_cnt = siren_cnt + 1'b1;
      blink_cnt = blink_cnt + 1'b1;
      if (siren_cnt == siren_len) begin
        siren_on  = 1'b0;
        siren_cnt = '0;
        blink_cnt = '0;
      end else if (blink_cnt == blink_len) begin
        blink_cnt = '0;
        toggle    = ~toggle;
        lamp      = toggle;
      end
    end
  endfunction

  function automatic actuator_levels_t current_levels();
    actuator_levels_t lv;
    lv.light      = light;
    lv.lamp       = lamp;
    lv.feed_angle = feed_pos;
    lv.door_angle = door_pos;
    lv.feed_busy  = feed_on;
    lv.door_busy  = door_on;
    lv.siren_busy = siren_on;
    return lv;
  endfunction

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    reset_model();
  end

  always @(posedge clk_i or negedge rst_ni) begin
    actuator_levels_t got, want;
    if (!rst_ni) begin
      reset_model();
      levels_due.delete();
    end else begin
      if (cfg_we_i) write_reg(cfg_idx_i, cfg_data_i);
      // take the result before predicting, a result never belongs to the same-edge tick
      if (levels_i.valid && levels_i.ready) begin
        got.light      = levels_i.light_level;
        got.lamp       = levels_i.siren_lamp;
        got.feed_angle = levels_i.feed_angle;
        got.door_angle = levels_i.door_angle;
        got.feed_busy  = levels_i.feed_busy;
        got.door_busy  = levels_i.door_busy;
        got.siren_busy = levels_i.siren_busy;
        if (levels_due.size() == 0) begin
          fail_count_o = fail_count_o + 1;
          if (fail_count_o <= 10) $display("%t: output item with no tick pending", $realtime);
        end else begin
          want = levels_due.pop_front();
          if (got.light !== want.light || got.lamp !== want.lamp ||
              got.feed_angle !== want.feed_angle || got.door_angle !== want.door_angle ||
              got.feed_busy !== want.feed_busy || got.door_busy !== want.door_busy ||
              got.siren_busy !== want.siren_busy) begin
            fail_count_o = fail_count_o + 1;
            if (fail_count_o <= 10)
              $display({"%t: mismatch light %b/%b lamp %b/%b feed %0d/%0d door %0d/%0d",
                        " busy %b%b%b/%b%b%b (exp/got)"},
                       $realtime, want.light, got.light, want.lamp, got.lamp,
                       want.feed_angle, got.feed_angle, want.door_angle, got.door_angle,
                       want.feed_busy, want.door_busy, want.siren_busy,
                       got.feed_busy, got.door_busy, got.siren_busy);
          end
        end
      end
      if (tick_i.valid && tick_i.ready) begin
        apply_tick(tick_i.cmd_valid, tick_i.cmd_code);
        levels_due.push_back(current_levels());
      end
    end
    pending_o = levels_due.size();
  end

endmodule

@@ tb/timed_actuator_pulse_controller_unit_tb.sv @@
// top of the pulse controller testbench: clock, reset, tick stimulus and register setup
// depends on tapc_pkg, both channel interfaces, the block and tapc_levels_checker
`timescale 1ns / 100ps

module timed_actuator_pulse_controller_unit_tb;
  import tapc_pkg::*;

  // command codes built from the bit positions of the package
  localparam logic [CODE_W-1:0] CMD_NONE      = '0;
  localparam logic [CODE_W-1:0] CMD_LIGHT_ON  = CODE_W'(1 << BIT_LIGHT_ON);
  localparam logic [CODE_W-1:0] CMD_LIGHT_OFF = CODE_W'(1 << BIT_LIGHT_OFF);
  localparam logic [CODE_W-1:0] CMD_DOOR      = CODE_W'(1 << BIT_DOOR);
  localparam logic [CODE_W-1:0] CMD_FEED      = CODE_W'(1 << BIT_FEED);
  localparam logic [CODE_W-1:0] CMD_SIREN     = CODE_W'(1 << BIT_SIREN);
  localparam logic [CODE_W-1:0] CMD_SPARE     = CODE_W'(1 << (CODE_W - 1));
  localparam logic [CODE_W-1:0] CMD_ALL       = '1;

  // cycles without any handshake before the run is declared hung
  localparam int QUIET_LIMIT  = 2000;
  // settle time after the last result; the block holds an input and a result register
  localparam int SETTLE_TICKS = 4;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  int fail_count;
  int pending;
  int quiet_cycles = 0;
  // idle percentages of the two sides, changed per phase
  int send_gap_pct = 15;
  int stall_pct    = 54;

  tapc_in_if  tick_if ();
  tapc_out_if levels_if ();

  timed_actuator_pulse_controller_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (tick_if),
    .out_o      (levels_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  tapc_levels_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tick_i       (tick_if),
    .levels_i     (levels_if),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // receiver back-pressure, one decision per cycle
  always @(negedge clk_i) begin
    levels_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  // hang detector: any handshake on either side restarts the count
  always @(posedge clk_i) begin
    if ((tick_if.valid && tick_if.ready) || (levels_if.valid && levels_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("FAIL timed_actuator_pulse_controller_unit");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // offer one tick, with a random number of idle cycles in front; returns at the
  // falling edge after acceptance with valid still high
  task automatic push_tick(input logic cv, input logic [CODE_W-1:0] code);
    while ($urandom_range(99) < send_gap_pct) begin
      tick_if.valid     = 1'b0;
      tick_if.cmd_valid = 1'($urandom_range(1));
      tick_if.cmd_code  = CODE_W'($urandom_range(2**CODE_W - 1));
      @(negedge clk_i);
    end
    tick_if.valid     = 1'b1;
    tick_if.cmd_valid = cv;
    tick_if.cmd_code  = code;
    @(posedge clk_i);
    while (!tick_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // random tick: mostly single commands, some ignored codes, some full noise
  task automatic random_tick();
    int pick;
    pick = $urandom_range(99);
    if (pick < 35) push_tick(1'b0, CODE_W'($urandom_range(2**CODE_W - 1)));
    else if (pick < 85) push_tick(1'b1, CODE_W'(1 << $urandom_range(CODE_W - 1)));
    else push_tick(1'b1, CODE_W'($urandom_range(2**CODE_W - 1)));
  endtask

  // stop sending and wait until every predicted item has come back
  task automatic wait_drained();
    tick_if.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_TICKS) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(negedge clk_i);
  endtask

  // all seven registers back to back, only while the block is idle
  task automatic load_settings(input logic [TICK_W-1:0] pulse, input logic [TICK_W-1:0] blink,
                               input logic [SIREN_W-1:0] siren,
                               input logic [ANGLE_W-1:0] fa, input logic [ANGLE_W-1:0] fr,
                               input logic [ANGLE_W-1:0] da, input logic [ANGLE_W-1:0] dr);
    write_reg(CFG_PULSE_TICKS, CFG_DATA_W'(pulse));
    write_reg(CFG_BLINK_TICKS, CFG_DATA_W'(blink));
    write_reg(CFG_SIREN_TICKS, CFG_DATA_W'(siren));
    write_reg(CFG_FEED_ACTIVE, CFG_DATA_W'(fa));
    write_reg(CFG_FEED_REST, CFG_DATA_W'(fr));
    write_reg(CFG_DOOR_ACTIVE, CFG_DATA_W'(da));
    write_reg(CFG_DOOR_REST, CFG_DATA_W'(dr));
    cfg_we_i = 1'b0;
  endtask

  initial begin
    logic [TICK_W-1:0] blink;
    tick_if.valid     = 1'b0;
    tick_if.cmd_valid = 1'b0;
    tick_if.cmd_code  = CMD_NONE;
    levels_if.ready   = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = CFG_PULSE_TICKS;
    cfg_data_i        = '0;

    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed ticks on reset settings: light control, clear beats set,
    // ignored codes, pulses with a retrigger, siren start
    push_tick(1'b1, CMD_NONE);
    push_tick(1'b1, CMD_LIGHT_OFF);
    push_tick(1'b0, CMD_ALL);
    push_tick(1'b1, CMD_LIGHT_ON);
    push_tick(1'b1, CMD_LIGHT_ON | CMD_LIGHT_OFF);
    push_tick(1'b1, CMD_FEED);
    push_tick(1'b1, CMD_DOOR);
    push_tick(1'b1, CMD_FEED);
    push_tick(1'b1, CMD_SIREN);
    push_tick(1'b1, CMD_SPARE);
    push_tick(1'b1, CMD_ALL);
    wait_drained();

    // shortest pulse, blink and siren, lowest angles
    load_settings(8'd1, 8'd1, 10'd1, 8'd0, 8'd0, 8'd0, 8'd0);
    push_tick(1'b1, CMD_FEED | CMD_DOOR | CMD_SIREN);
    push_tick(1'b1, CMD_SIREN);
    push_tick(1'b1, CMD_NONE);
    wait_drained();

    // longest settings, angles past the servo range
    load_settings(8'd255, 8'd255, 10'd1023, 8'd255, 8'd180, 8'd255, 8'd180);
    push_tick(1'b1, CMD_FEED | CMD_DOOR | CMD_SIREN | CMD_LIGHT_ON);
    push_tick(1'b0, CMD_NONE);
    push_tick(1'b1, CMD_FEED);
    push_tick(1'b1, CMD_DOOR | CMD_LIGHT_OFF);
    wait_drained();

    // short random timings with the siren a whole number of blinks
    blink = TICK_W'($urandom_range(1, 12));
    load_settings(TICK_W'($urandom_range(1, 30)), blink,
                  SIREN_W'(blink * $urandom_range(1, 8)),
                  ANGLE_W'($urandom_range(0, 180)), ANGLE_W'($urandom_range(0, 180)),
                  ANGLE_W'($urandom_range(0, 180)), ANGLE_W'($urandom_range(0, 180)));
    repeat (450) random_tick();
    wait_drained();

    // roles swapped: busy sender gaps, light receiver stalls; siren length
    // unrelated to the blink interval, any angle
    send_gap_pct = 54;
    stall_pct    = 15;
    load_settings(TICK_W'($urandom_range(1, 40)), TICK_W'($urandom_range(1, 16)),
                  SIREN_W'($urandom_range(1, 120)),
                  ANGLE_W'($urandom_range(0, 255)), ANGLE_W'($urandom_range(0, 255)),
                  ANGLE_W'($urandom_range(0, 255)), ANGLE_W'($urandom_range(0, 255)));
    repeat (450) random_tick();
    wait_drained();

    // zero lengths: every counter wraps, so the siren needs 1024 ticks to end
    send_gap_pct = 0;
    stall_pct    = 0;
    load_settings(8'd0, 8'd0, 10'd0,
                  ANGLE_W'($urandom_range(0, 255)), ANGLE_W'($urandom_range(0, 255)),
                  ANGLE_W'($urandom_range(0, 255)), ANGLE_W'($urandom_range(0, 255)));
    repeat (500) random_tick();
    // hold the sender until the pipeline is empty, state carries over
    wait_drained();
    repeat (500) random_tick();
    wait_drained();

    if (fail_count == 0 && pending == 0) begin
      $display("PASS timed_actuator_pulse_controller_unit");
    end else begin
      $display("FAIL timed_actuator_pulse_controller_unit");
    end
    $finish;
  end

endmodule
